// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the parser modules
// both expect a signal named clk in the calling scope; HCP_ASSERT also needs rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HCP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcp_pkg
// Shared types and constants of the hex text frame line parser.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int LINE_BUFFER_DEF = 160;
  localparam int MAX_BYTES_DEF   = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int OUT_BYTES       = 8;

  localparam int CHAR_W     = 8;
  localparam int ID_W       = 29;
  localparam int CNT_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int ACC_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int CFG_DATA_W = 29;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT = 1'b1;

  localparam logic [ID_W-1:0]  ID_LIMIT_RST   = 29'd2047;
  localparam logic [CNT_W-1:0] DATA_LIMIT_RST = 4'd8;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_ID   = 2'd1,
    STAT_BAD_DATA = 2'd2,
    STAT_TOO_MANY = 2'd3
  } hcp_status_t;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_LEAD    = 3'd1,
    PH_SIGN    = 3'd2,
    PH_ZERO    = 3'd3,
    PH_PREFIX  = 3'd4,
    PH_DIGITS  = 3'd5,
    PH_BAD     = 3'd6
  } hcp_phase_t;

  typedef enum logic [3:0] {
    CLS_SKIP  = 4'd0,
    CLS_SPACE = 4'd1,
    CLS_WS    = 4'd2,
    CLS_PLUS  = 4'd3,
    CLS_MINUS = 4'd4,
    CLS_ZERO  = 4'd5,
    CLS_X     = 4'd6,
    CLS_HEX   = 4'd7,
    CLS_OTHER = 4'd8
  } hcp_class_t;

  // one classified character on its way from front to back
  typedef struct packed {
    hcp_class_t         cls;
    logic [DIGIT_W-1:0] digit;
    logic               eol;
  } hcp_entry_t;

endpackage

// ===== rtl/hcp_if.sv =====
// ----------------------------------------------------------------------------
// hcp_in_if / hcp_out_if
// Valid/ready channels of the parser: characters in, frames out.
// ----------------------------------------------------------------------------
interface hcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [hcp_pkg::CHAR_W-1:0]  char_byte;
  logic                        end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface hcp_out_if;
  logic                          valid;
  logic                          ready;
  logic [hcp_pkg::STATUS_W-1:0]  status;
  logic [hcp_pkg::ID_W-1:0]      frame_id;
  logic [hcp_pkg::CNT_W-1:0]     byte_count;
  logic [hcp_pkg::BYTE_W-1:0]    byte_0;
  logic [hcp_pkg::BYTE_W-1:0]    byte_1;
  logic [hcp_pkg::BYTE_W-1:0]    byte_2;
  logic [hcp_pkg::BYTE_W-1:0]    byte_3;
  logic [hcp_pkg::BYTE_W-1:0]    byte_4;
  logic [hcp_pkg::BYTE_W-1:0]    byte_5;
  logic [hcp_pkg::BYTE_W-1:0]    byte_6;
  logic [hcp_pkg::BYTE_W-1:0]    byte_7;

  modport source (output valid, output status, output frame_id, output byte_count,
                  output byte_0, output byte_1, output byte_2, output byte_3,
                  output byte_4, output byte_5, output byte_6, output byte_7,
                  input ready);
  modport sink   (input valid, input status, input frame_id, input byte_count,
                  input byte_0, input byte_1, input byte_2, input byte_3,
                  input byte_4, input byte_5, input byte_6, input byte_7,
                  output ready);
endinterface

// ===== rtl/hcp_front.sv =====
// ----------------------------------------------------------------------------
// hcp_front
// Accepts characters, applies line cut and length limit, classifies them.
// ----------------------------------------------------------------------------
module hcp_front #(
  parameter int LINE_BUFFER = hcp_pkg::LINE_BUFFER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  hcp_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                push,
  output hcp_pkg::hcp_entry_t push_entry
);

  localparam int CW = $clog2(LINE_BUFFER);

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            cut_r, cut_nxt;
  logic                            take;
  hcp_pkg::hcp_class_t             raw_cls;
  logic [hcp_pkg::DIGIT_W-1:0]     raw_digit;
  logic [hcp_pkg::CHAR_W-1:0]      c;

  assign c           = in_ch.char_byte;
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // character decoder
  always_comb begin
    raw_cls   = hcp_pkg::CLS_OTHER;
    raw_digit = '0;
    unique case (c) inside
      8'h20:          raw_cls = hcp_pkg::CLS_SPACE;
      [8'h09:8'h0D]:  raw_cls = hcp_pkg::CLS_WS;
      8'h2B:          raw_cls = hcp_pkg::CLS_PLUS;
      8'h2D:          raw_cls = hcp_pkg::CLS_MINUS;
      8'h30:          raw_cls = hcp_pkg::CLS_ZERO;
      8'h58, 8'h78:   raw_cls = hcp_pkg::CLS_X;
      [8'h31:8'h39]: begin
        raw_cls   = hcp_pkg::CLS_HEX;
        raw_digit = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        raw_cls   = hcp_pkg::CLS_HEX;
        raw_digit = c[3:0] + 4'd9;
      end
      default:        raw_cls = hcp_pkg::CLS_OTHER;
    endcase
  end

  assign take = !cut_r && (c != '0) && (cnt_r < CW'(LINE_BUFFER - 1));

  always_comb begin
    cnt_nxt = cnt_r;
    cut_nxt = cut_r;
    if (push) begin
      if (!cut_r && c == '0) begin
        cut_nxt = 1'b1;
      end
      if (take) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      // line state restarts after the last character
      if (in_ch.end_of_line) begin
        cnt_nxt = '0;
        cut_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    push_entry.cls   = take ? raw_cls : hcp_pkg::CLS_SKIP;
    push_entry.digit = raw_digit;
    push_entry.eol   = in_ch.end_of_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cut_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      cut_r <= cut_nxt;
    end
  end

endmodule

// ===== rtl/hcp_queue.sv =====
// ----------------------------------------------------------------------------
// hcp_queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hcp_pkg::hcp_entry_t push_entry,
  output logic                full,
  output logic                valid,
  output hcp_pkg::hcp_entry_t head,
  input  logic                pop
);

  localparam int PW = $clog2(hcp_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(hcp_pkg::QUEUE_DEPTH + 1);

  hcp_pkg::hcp_entry_t mem_r [hcp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_r, wr_nxt;
  logic [PW-1:0]       rd_r, rd_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic                do_pop;

  assign full   = (count_r == NW'(hcp_pkg::QUEUE_DEPTH));
  assign valid  = (count_r != '0);
  assign head   = mem_r[rd_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = do_pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  `HCP_ASSERT(a_q_no_overflow, count_r <= NW'(hcp_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `HCP_ASSERT(a_q_ptr_gap, (count_r == '0) || (count_r == NW'(hcp_pkg::QUEUE_DEPTH)) || (wr_r != rd_r), "queue pointers disagree with count")
  `HCP_ASSERT_RST(a_q_reset, !rst_n |=> count_r == '0, "queue not empty after reset")

endmodule

// ===== rtl/hcp_back.sv =====
// ----------------------------------------------------------------------------
// hcp_back
// Token state machine, frame assembly, configuration and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcp_back #(
  parameter int MAX_BYTES = hcp_pkg::MAX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  hcp_pkg::hcp_entry_t              q_head,
  output logic                             q_pop,
  input  logic                             cfg_we,
  input  logic [hcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  hcp_out_if.source                        out_ch
);

  localparam int TW = $clog2(MAX_BYTES + 2);
  localparam int AW = hcp_pkg::ACC_W;
  localparam int NB = hcp_pkg::OUT_BYTES;

  // configuration
  logic [hcp_pkg::ID_W-1:0]   id_limit_r;
  logic [hcp_pkg::CNT_W-1:0]  data_limit_r;

  // token and line state
  hcp_pkg::hcp_phase_t        phase_r, phase_nxt;
  logic [AW-1:0]              acc_r, acc_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       minus_r, minus_nxt;
  logic [TW-1:0]              tok_r, tok_nxt;
  hcp_pkg::hcp_status_t       err_r, err_nxt;
  logic [hcp_pkg::ID_W-1:0]   held_id_r, held_id_nxt;
  logic [hcp_pkg::BYTE_W-1:0] held_r [NB];
  logic [hcp_pkg::BYTE_W-1:0] held_nxt [NB];

  // result register
  logic                       out_valid_r, out_valid_nxt;
  hcp_pkg::hcp_status_t       out_status_r, out_status_nxt;
  logic [hcp_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [hcp_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [hcp_pkg::BYTE_W-1:0] out_bytes_r [NB];
  logic [hcp_pkg::BYTE_W-1:0] out_bytes_nxt [NB];

  // per character working values
  hcp_pkg::hcp_phase_t        s_phase, f_phase;
  logic [AW-1:0]              s_acc, f_acc, a_acc;
  logic                       s_ovf, f_ovf, a_ovf;
  logic                       s_minus, f_minus;
  logic                       finish, ok_base, id_ok, byte_ok;
  logic [31:0]                lim, n_cur, n_fin;
  hcp_pkg::hcp_status_t       fin_err;
  logic                       load;
  hcp_pkg::hcp_class_t        cls;

  assign cls   = q_head.cls;
  // a line end waits for room in the result register
  assign q_pop = q_valid && (!q_head.eol || !out_valid_r || out_ch.ready);
  assign load  = q_pop && q_head.eol;

  assign lim   = (32'(data_limit_r) < 32'(MAX_BYTES)) ? 32'(data_limit_r) : 32'(MAX_BYTES);
  assign n_cur = 32'(tok_r) - 32'd1;

  // character step of the token machine
  always_comb begin
    s_phase = phase_r;
    s_acc   = acc_r;
    s_ovf   = ovf_r;
    s_minus = minus_r;
    if (q_pop && cls != hcp_pkg::CLS_SPACE && cls != hcp_pkg::CLS_SKIP &&
        phase_r == hcp_pkg::PH_BETWEEN) begin
      s_phase = hcp_pkg::PH_LEAD;
      s_acc   = '0;
      s_ovf   = 1'b0;
      s_minus = 1'b0;
    end
    // saturating shift-in of one hex digit
    a_ovf = s_ovf || (s_acc[AW-1:AW-4] != '0);
    if (s_ovf) begin
      a_acc = s_acc;
    end else if (s_acc[AW-1:AW-4] != '0) begin
      a_acc = '1;
    end else begin
      a_acc = {s_acc[AW-5:0], q_head.digit};
    end
    f_phase = s_phase;
    f_acc   = s_acc;
    f_ovf   = s_ovf;
    f_minus = s_minus;
    if (q_pop && cls != hcp_pkg::CLS_SPACE && cls != hcp_pkg::CLS_SKIP) begin
      unique case (s_phase)
        hcp_pkg::PH_LEAD: begin
          if (cls == hcp_pkg::CLS_WS) begin
            f_phase = hcp_pkg::PH_LEAD;
          end else if (cls == hcp_pkg::CLS_PLUS || cls == hcp_pkg::CLS_MINUS) begin
            f_minus = (cls == hcp_pkg::CLS_MINUS);
            f_phase = hcp_pkg::PH_SIGN;
          end else if (cls == hcp_pkg::CLS_ZERO) begin
            f_phase = hcp_pkg::PH_ZERO;
          end else if (cls == hcp_pkg::CLS_HEX) begin
            f_acc   = AW'(q_head.digit);
            f_phase = hcp_pkg::PH_DIGITS;
          end else begin
            f_phase = hcp_pkg::PH_BAD;
          end
        end
        hcp_pkg::PH_SIGN: begin
          if (cls == hcp_pkg::CLS_ZERO) begin
            f_phase = hcp_pkg::PH_ZERO;
          end else if (cls == hcp_pkg::CLS_HEX) begin
            f_acc   = a_acc;
            f_ovf   = a_ovf;
            f_phase = hcp_pkg::PH_DIGITS;
          end else begin
            f_phase = hcp_pkg::PH_BAD;
          end
        end
        hcp_pkg::PH_ZERO: begin
          if (cls == hcp_pkg::CLS_X) begin
            f_phase = hcp_pkg::PH_PREFIX;
          end else if (cls == hcp_pkg::CLS_HEX || cls == hcp_pkg::CLS_ZERO) begin
            f_acc   = a_acc;
            f_ovf   = a_ovf;
            f_phase = hcp_pkg::PH_DIGITS;
          end else begin
            f_phase = hcp_pkg::PH_BAD;
          end
        end
        hcp_pkg::PH_PREFIX, hcp_pkg::PH_DIGITS: begin
          if (cls == hcp_pkg::CLS_HEX || cls == hcp_pkg::CLS_ZERO) begin
            f_acc   = a_acc;
            f_ovf   = a_ovf;
            f_phase = hcp_pkg::PH_DIGITS;
          end else begin
            f_phase = hcp_pkg::PH_BAD;
          end
        end
        default: f_phase = hcp_pkg::PH_BAD;
      endcase
    end
  end

  // token close and line assembly
  always_comb begin
    finish  = q_pop && (cls == hcp_pkg::CLS_SPACE || q_head.eol) &&
              (f_phase != hcp_pkg::PH_BETWEEN);
    ok_base = (f_phase == hcp_pkg::PH_ZERO || f_phase == hcp_pkg::PH_DIGITS) &&
              !f_ovf && !(f_minus && f_acc != '0);
    id_ok   = ok_base && (f_acc <= AW'(id_limit_r));
    byte_ok = ok_base && (f_acc[AW-1:hcp_pkg::BYTE_W] == '0);

    phase_nxt   = finish ? hcp_pkg::PH_BETWEEN : f_phase;
    acc_nxt     = f_acc;
    ovf_nxt     = f_ovf;
    minus_nxt   = f_minus;
    tok_nxt     = tok_r;
    err_nxt     = err_r;
    held_id_nxt = held_id_r;
    held_nxt    = held_r;

    if (finish && err_r == hcp_pkg::STAT_OK) begin
      if (tok_r == '0) begin
        if (id_ok) begin
          held_id_nxt = f_acc[hcp_pkg::ID_W-1:0];
          tok_nxt     = TW'(1);
        end else begin
          err_nxt = hcp_pkg::STAT_BAD_ID;
        end
      end else if (n_cur >= lim) begin
        err_nxt = hcp_pkg::STAT_TOO_MANY;
      end else if (!byte_ok) begin
        err_nxt = hcp_pkg::STAT_BAD_DATA;
      end else begin
        for (int k = 0; k < NB; k++) begin
          if (32'(k) == n_cur) begin
            held_nxt[k] = f_acc[hcp_pkg::BYTE_W-1:0];
          end
        end
        tok_nxt = tok_r + 1'b1;
      end
    end

    fin_err = (err_nxt == hcp_pkg::STAT_OK && tok_nxt == '0) ? hcp_pkg::STAT_BAD_ID : err_nxt;
    n_fin   = 32'(tok_nxt) - 32'd1;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_cnt_nxt    = out_cnt_r;
    out_bytes_nxt  = out_bytes_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_err;
      out_id_nxt     = (fin_err == hcp_pkg::STAT_OK) ? held_id_nxt : '0;
      out_cnt_nxt    = (fin_err == hcp_pkg::STAT_OK) ? n_fin[hcp_pkg::CNT_W-1:0] : '0;
      for (int k = 0; k < NB; k++) begin
        out_bytes_nxt[k] = (fin_err == hcp_pkg::STAT_OK && 32'(k) < n_fin) ?
                           held_nxt[k] : '0;
      end
      // line state restarts
      phase_nxt = hcp_pkg::PH_BETWEEN;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      minus_nxt = 1'b0;
      tok_nxt   = '0;
      err_nxt   = hcp_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r   <= hcp_pkg::ID_LIMIT_RST;
      data_limit_r <= hcp_pkg::DATA_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcp_pkg::CFG_ID_LIMIT:   id_limit_r   <= cfg_wdata[hcp_pkg::ID_W-1:0];
        hcp_pkg::CFG_DATA_LIMIT: data_limit_r <= cfg_wdata[hcp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hcp_pkg::PH_BETWEEN;
      ovf_r       <= 1'b0;
      minus_r     <= 1'b0;
      tok_r       <= '0;
      err_r       <= hcp_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ovf_r       <= ovf_nxt;
      minus_r     <= minus_nxt;
      tok_r       <= tok_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    held_id_r    <= held_id_nxt;
    held_r       <= held_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.frame_id   = out_id_r;
  assign out_ch.byte_count = out_cnt_r;
  assign out_ch.byte_0     = out_bytes_r[0];
  assign out_ch.byte_1     = out_bytes_r[1];
  assign out_ch.byte_2     = out_bytes_r[2];
  assign out_ch.byte_3     = out_bytes_r[3];
  assign out_ch.byte_4     = out_bytes_r[4];
  assign out_ch.byte_5     = out_bytes_r[5];
  assign out_ch.byte_6     = out_bytes_r[6];
  assign out_ch.byte_7     = out_bytes_r[7];

  `HCP_ASSERT(a_tok_bound, tok_r <= TW'(MAX_BYTES + 1), "token index beyond byte limit")
  `HCP_ASSERT(a_line_clear, load |=> (tok_r == '0) && (err_r == hcp_pkg::STAT_OK), "line state not cleared after line end")
  `HCP_ASSERT(a_out_source, $rose(out_valid_r) |-> $past(load), "result shown without a line end")

endmodule

// ===== rtl/hex_text_can_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_text_can_frame_parser_top
// Parses a text line of hex tokens, one character per request, into a frame.
// ----------------------------------------------------------------------------
// in_ch carries one character per request with end_of_line on the last one;
// out_ch carries one frame request per line: status, frame_id, byte_count and
// eight data bytes (zero when absent or when status is not ok).
// cfg_we/cfg_index/cfg_wdata write id_limit (index 0) and data_limit
// (index 1); write them only while no line is in flight.
// Throughput is one character per cycle while in_ch.ready is high. The front
// classifies the character in the cycle it is accepted and drops it into a
// two-entry queue; the back runs the token machine on it when it reaches the
// queue head and, on a line end, loads the result register, whose outputs
// drive out_ch.
// A held result does not stop the back from working on the next line; only
// a second line end waits for the result register, and then the queue fills
// and in_ch.ready falls after one more character.
// Reset (synchronous, rst_n low) empties the queue and result register,
// clears the line state and restores id_limit to 2047 and data_limit to 8.
// ----------------------------------------------------------------------------
module hex_text_can_frame_parser_top #(
  parameter int LINE_BUFFER = hcp_pkg::LINE_BUFFER_DEF,
  parameter int MAX_BYTES   = hcp_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hcp_in_if.sink                          in_ch,
  hcp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                push;
  hcp_pkg::hcp_entry_t push_entry;
  logic                q_full;
  logic                q_valid;
  hcp_pkg::hcp_entry_t q_head;
  logic                q_pop;

  hcp_front #(
    .LINE_BUFFER (LINE_BUFFER)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  hcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  hcp_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule
